@@ hw/rtl/iialu_pkg.sv @@
package iialu_pkg;

    // Default datapath width and fixed field widths
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int ACTION_W       = 3;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DIV = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REM = 3'd4;

    // Command transfer
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  operand_a;
        logic [VALUE_W-1:0]  operand_b;
    } cmd_t;

    // Response transfer
    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               result_is_zero;
        logic               divide_by_zero;
    } rsp_t;

    // Sequencer to datapath strobes
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } dp_ctrl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/bitwise_iterative_integer_alu.sv @@
// A command is loaded in idle, stepped DATA_WIDTH times in the busy state, then captured
// into the output register in the done state; no new command is taken before that capture.
// The step counter runs one multiplier, quotient or sum bit per cycle.
// A finished result waits in the output register while the next command is taken.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops rsp_valid.
module bitwise_iterative_integer_alu #(
    parameter int DATA_WIDTH = iialu_pkg::DATA_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  iialu_pkg::cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output iialu_pkg::rsp_t rsp
);
    import iialu_pkg::*;

    dp_ctrl_t ctrl;

    // Sequencer
    iialu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl)
    );

    // Bit-serial datapath
    iialu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk  (clk),
        .ctrl (ctrl),
        .cmd  (cmd),
        .rsp  (rsp)
    );

endmodule

@@ hw/rtl/iialu_ctrl.sv @@
module iialu_ctrl #(
    parameter int DATA_WIDTH = iialu_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output iialu_pkg::dp_ctrl_t ctrl
);
    import iialu_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (cnt_reg == LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: strobes and stall
    always_comb
    begin
        cmd_stall    = 1'b1;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        ctrl.capture = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                ctrl.load = cmd_valid;
            end
            ST_BUSY: ctrl.step = 1'b1;
            ST_DONE: ctrl.capture = !rsp_valid_reg || !rsp_stall;
            default: cmd_stall = 1'b1;
        endcase
    end

    // Step counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.load)
            cnt_next = '0;
        else if (ctrl.step)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    // Response valid: set on capture, held while stalled
    assign rsp_valid_next = ctrl.capture || (rsp_valid_reg && rsp_stall);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // A load starts a fresh pass of steps
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (state_reg == ST_BUSY) && (cnt_reg == '0))
        else $error("load did not start the step sequence");

    // The pass ends after exactly DATA_WIDTH steps
    a_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY) && (cnt_reg == LAST) |=> state_reg == ST_DONE)
        else $error("step sequence overran");

    // A capture always presents a response next cycle
    a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> rsp_valid_reg && (state_reg == ST_IDLE))
        else $error("captured result not presented");

endmodule

@@ hw/rtl/iialu_dp.sv @@
module iialu_dp #(
    parameter int DATA_WIDTH = iialu_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  iialu_pkg::dp_ctrl_t ctrl,
    input  iialu_pkg::cmd_t     cmd,
    output iialu_pkg::rsp_t     rsp
);
    import iialu_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int MAXW = (W > VALUE_W) ? W : VALUE_W;

    logic [ACTION_W-1:0] op_reg;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [W-1:0]        res_reg, res_next;
    logic                carry_reg, carry_next;
    rsp_t                rsp_reg;

    logic [MAXW-1:0] ext_a, ext_b, ext_val;
    logic            is_sub, b_bit, sum_bit;
    logic [W-1:0]    mul_sum;
    logic [W+1:0]    trial;
    logic            borrow;
    logic            dbz;
    logic [W-1:0]    fin_val;

    // Operands fitted to the datapath width
    assign ext_a = MAXW'(cmd.operand_a);
    assign ext_b = MAXW'(cmd.operand_b);

    // Serial adder: one sum bit per step, LSB first
    assign is_sub  = (op_reg == ACT_SUB);
    assign b_bit   = b_reg[0] ^ is_sub;
    assign sum_bit = a_reg[0] ^ b_bit ^ carry_reg;

    // Shift-add partial sum
    assign mul_sum = res_reg + a_reg;

    // Restoring division trial subtract on partial remainder
    assign trial  = {1'b0, res_reg, a_reg[W-1]} - {2'b00, b_reg};
    assign borrow = trial[W+1];

    // One step of the selected operation
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        carry_next = carry_reg;
        unique case (op_reg)
            ACT_ADD, ACT_SUB:
            begin
                a_next     = {1'b0, a_reg[W-1:1]};
                b_next     = {1'b0, b_reg[W-1:1]};
                res_next   = {sum_bit, res_reg[W-1:1]};
                carry_next = (a_reg[0] & b_bit) | (carry_reg & (a_reg[0] ^ b_bit));
            end
            ACT_MUL:
            begin
                if (b_reg[0])
                    res_next = mul_sum;
                a_next = {a_reg[W-2:0], 1'b0};
                b_next = {1'b0, b_reg[W-1:1]};
            end
            ACT_DIV, ACT_REM:
            begin
                if (!borrow)
                begin
                    res_next = trial[W-1:0];
                    a_next   = {a_reg[W-2:0], 1'b1};
                end
                else
                begin
                    res_next = {res_reg[W-2:0], a_reg[W-1]};
                    a_next   = {a_reg[W-2:0], 1'b0};
                end
            end
            default: res_next = res_reg;
        endcase
    end

    // Final result select
    assign dbz = ((op_reg == ACT_DIV) || (op_reg == ACT_REM)) && (b_reg == '0);

    always_comb
    begin
        fin_val = '0;
        priority if (dbz)
            fin_val = '0;
        else if (op_reg == ACT_DIV)
            fin_val = a_reg;
        else if ((op_reg == ACT_ADD) || (op_reg == ACT_SUB) || (op_reg == ACT_MUL) ||
                 (op_reg == ACT_REM))
            fin_val = res_reg;
        else
            fin_val = '0;
    end

    assign ext_val = MAXW'(fin_val);

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg    <= cmd.action;
            a_reg     <= ext_a[W-1:0];
            b_reg     <= ext_b[W-1:0];
            res_reg   <= '0;
            carry_reg <= (cmd.action == ACT_SUB);
        end
        else if (ctrl.step)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            res_reg   <= res_next;
            carry_reg <= carry_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            rsp_reg.result_value   <= ext_val[VALUE_W-1:0];
            rsp_reg.result_is_zero <= (fin_val == '0);
            rsp_reg.divide_by_zero <= dbz;
        end
    end

    assign rsp = rsp_reg;

endmodule
